/* hw/rtl/key_matrix_edge_scanner_assert.svh */
// ----------------------------------------------------------------------------
// Key matrix edge scanner assertion macros
// Shared concurrent-assertion helpers clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KEY_MATRIX_EDGE_SCANNER_ASSERT_SVH
`define KEY_MATRIX_EDGE_SCANNER_ASSERT_SVH

// same-cycle implication
`define KMES_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KMES_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/kmes_pkg.sv */
// ----------------------------------------------------------------------------
// kmes_pkg
// Shared constants, codes and types of the key matrix edge scanner.
// ----------------------------------------------------------------------------
package kmes_pkg;

    localparam int ROWS_DEF  = 8;
    localparam int COLS_DEF  = 16;
    localparam int MAX_ROWS  = 8;    // row_bits width
    localparam int MAP_DEPTH = 16;   // key map entries
    localparam int COL_W     = 4;
    localparam int ROW_W     = 3;
    localparam int CFG_W     = 5;

    localparam logic [1:0] KIND_PRESS   = 2'd0;
    localparam logic [1:0] KIND_HOLD    = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;
    localparam logic [1:0] KIND_DONE    = 2'd3;

    localparam logic             CFG_IDX_COLS = 1'b0;
    localparam logic [CFG_W-1:0] CFG_COLS_RST = 5'd16;

    // one column sample handed to the event emitter
    typedef struct packed {
        logic [MAX_ROWS-1:0] now;
        logic [COL_W-1:0]    col;
        logic                last_col;
    } t_item;

endpackage

/* hw/rtl/key_matrix_edge_scanner.sv */
// ----------------------------------------------------------------------------
// key_matrix_edge_scanner
// Compares each column sample with the stored key map and emits key events.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  input     i_valid / o_ready     i_row_bits
//  output    o_valid / i_ready     o_event_kind, o_key_row, o_key_col,
//                                  o_clear_press_count, o_last
//  config    APB psel/penable      paddr, pwdata, prdata (cols_in_use at 0x0)
//
//  An item yields one result per row down now or before, then a column done
//  result; the emitter produces one result per cycle while the output is not stalled.
//  The next item is accepted in the cycle its predecessor's column done
//  result is loaded into the output register, so items run back to back.
//  Reset is synchronous; map entries have valid bits cleared at once, no sweep.
//  A stalled output holds the emitter; the map is read and rewritten at accept.
// ----------------------------------------------------------------------------
module key_matrix_edge_scanner #(
    parameter int ROWS = kmes_pkg::ROWS_DEF,
    parameter int COLS = kmes_pkg::COLS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // sample channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [kmes_pkg::MAX_ROWS-1:0] i_row_bits,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_event_kind,
    output logic [kmes_pkg::ROW_W-1:0]    o_key_row,
    output logic [kmes_pkg::COL_W-1:0]    o_key_col,
    output logic                          o_clear_press_count,
    output logic                          o_last,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import kmes_pkg::*;

    // rows examined and columns usable
    localparam int ROWS_USED = (ROWS > MAX_ROWS) ? MAX_ROWS : ((ROWS < 1) ? 1 : ROWS);
    localparam int COL_LIM   = (COLS > MAP_DEPTH) ? MAP_DEPTH : ((COLS < 1) ? 1 : COLS);
    localparam logic [CFG_W-1:0] ColLim = CFG_W'(COL_LIM);

    logic [CFG_W-1:0]     r_cols;
    logic [COL_W-1:0]     r_col;
    logic [CFG_W-1:0]     eff_cols;
    logic                 last_col;
    logic                 accept;
    logic                 take;
    logic                 busy;
    logic [MAX_ROWS-1:0]  now8;
    logic [ROWS_USED-1:0] prev_map;
    t_item                item;
    logic                 out_done;
    logic                 done_ok;

    // ---------------- configuration ----------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= CFG_COLS_RST;
        end else if (psel && penable && pwrite && (paddr[2] == CFG_IDX_COLS)) begin
            r_cols <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == CFG_IDX_COLS) ? {{(32 - CFG_W){1'b0}}, r_cols} : 32'd0;

    // zero acts as one, large values saturate to COLS, capped at the map depth
    always_comb begin
        if (r_cols == '0) begin
            eff_cols = CFG_W'(1);
        end else if (r_cols > ColLim) begin
            eff_cols = ColLim;
        end else begin
            eff_cols = r_cols;
        end
    end

    // a column at or past the last counted one closes the scan
    assign last_col = ({1'b0, r_col} + CFG_W'(1)) >= eff_cols;

    // ---------------- intake and column counter ----------------
    assign o_ready = take;
    assign accept  = i_valid && take;

    always_comb begin
        now8 = '0;
        now8[ROWS_USED-1:0] = i_row_bits[ROWS_USED-1:0];
        item.now      = now8;
        item.col      = r_col;
        item.last_col = last_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (accept) begin
            r_col <= last_col ? '0 : (r_col + COL_W'(1));
        end
    end

    // ---------------- key map store ----------------
    kmes_map #(
        .ROWS_USED (ROWS_USED)
    ) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (accept),
        .i_addr  (r_col),
        .i_wdata (i_row_bits[ROWS_USED-1:0]),
        .o_rdata (prev_map)
    );

    // ---------------- event emitter ----------------
    kmes_emit #(
        .ROWS_USED (ROWS_USED)
    ) u_emit (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_load              (accept),
        .i_item              (item),
        .i_before            (prev_map),
        .o_take              (take),
        .o_busy              (busy),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_event_kind        (o_event_kind),
        .o_key_row           (o_key_row),
        .o_key_col           (o_key_col),
        .o_clear_press_count (o_clear_press_count),
        .o_last              (o_last)
    );

    // ---------------- assertions ----------------
`include "key_matrix_edge_scanner_assert.svh"

    assign out_done = (o_event_kind == KIND_DONE);
    assign done_ok  = o_last && out_done;

    `KMES_ASSERT_NOW(a_clr_on_done, o_valid && o_clear_press_count, done_ok, "stray clear flag")
    `KMES_ASSERT_NOW(a_last_is_done, o_valid, o_last == out_done, "last and done kind disagree")
    `KMES_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted item not held by emitter")

endmodule

/* hw/rtl/kmes_map.sv */
// ----------------------------------------------------------------------------
// kmes_map
// Previous key map store: one entry per column, read and rewritten per item.
// ----------------------------------------------------------------------------
module kmes_map #(
    parameter int ROWS_USED = kmes_pkg::ROWS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_we,
    input  logic [kmes_pkg::COL_W-1:0] i_addr,
    input  logic [ROWS_USED-1:0]       i_wdata,
    output logic [ROWS_USED-1:0]       o_rdata
);
    import kmes_pkg::*;

    logic [ROWS_USED-1:0] r_mem [MAP_DEPTH];
    logic [MAP_DEPTH-1:0] r_vld;
    logic [ROWS_USED-1:0] r_rd;
    logic                 r_rd_vld;

    // read returns the old entry while the new map is written
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_rd          <= r_mem[i_addr];
            r_mem[i_addr] <= i_wdata;
        end
    end

    // entries never written read as no keys down
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else if (i_we) begin
            r_rd_vld      <= r_vld[i_addr];
            r_vld[i_addr] <= 1'b1;
        end
    end

    assign o_rdata = r_rd_vld ? r_rd : '0;

endmodule

/* hw/rtl/kmes_emit.sv */
// ----------------------------------------------------------------------------
// kmes_emit
// Walks a column's active rows, a result per unstalled cycle, then column done.
// ----------------------------------------------------------------------------
module kmes_emit #(
    parameter int ROWS_USED = kmes_pkg::ROWS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  kmes_pkg::t_item            i_item,
    input  logic [ROWS_USED-1:0]       i_before,
    output logic                       o_take,
    output logic                       o_busy,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [1:0]                 o_event_kind,
    output logic [kmes_pkg::ROW_W-1:0] o_key_row,
    output logic [kmes_pkg::COL_W-1:0] o_key_col,
    output logic                       o_clear_press_count,
    output logic                       o_last
);
    import kmes_pkg::*;

    t_item               r_item;
    logic                r_busy;
    logic                r_fresh;
    logic [MAX_ROWS-1:0] r_pend;
    logic [8:0]          r_count;
    logic                r_valid;
    logic [1:0]          r_kind;
    logic [ROW_W-1:0]    r_row;
    logic [COL_W-1:0]    r_col;
    logic                r_clr;
    logic                r_last;

    logic [MAX_ROWS-1:0] before8;
    logic [MAX_ROWS-1:0] cur_pend;
    logic [MAX_ROWS-1:0] n_pend;
    logic [ROW_W-1:0]    idx;
    logic                found;
    logic                step;
    logic [8:0]          n_count;
    logic                n_busy;
    logic                n_fresh;

    always_comb begin
        before8 = '0;
        before8[ROWS_USED-1:0] = i_before;
        cur_pend = r_fresh ? (r_item.now | before8) : r_pend;
        idx   = '0;
        found = 1'b0;
        for (int r = ROWS_USED - 1; r >= 0; r--) begin
            if (cur_pend[r]) begin
                idx   = ROW_W'(r);
                found = 1'b1;
            end
        end
        n_pend = cur_pend;
        n_pend[idx] = 1'b0;
        step = r_busy && (!r_valid || i_ready);
        n_count = r_count;
        if (r_item.now[idx] && !before8[idx]) begin
            n_count = r_count + 9'd1;
        end else if (!r_item.now[idx] && before8[idx]) begin
            n_count = r_count - 9'd1;
        end
        // a load in the column-done cycle keeps the emitter busy
        n_busy  = r_busy;
        n_fresh = r_fresh;
        if (step) begin
            n_fresh = 1'b0;
            if (!found) begin
                n_busy = 1'b0;
            end
        end
        if (i_load) begin
            n_busy  = 1'b1;
            n_fresh = 1'b1;
        end
    end

    assign o_take = !r_busy || (step && !found);
    assign o_busy = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_fresh <= 1'b0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_fresh <= n_fresh;
            if (step) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            if (step) begin
                r_pend  <= n_pend;
                r_col   <= r_item.col;
                if (found) begin
                    r_row   <= idx;
                    r_clr   <= 1'b0;
                    r_last  <= 1'b0;
                    r_count <= n_count;
                    if (r_item.now[idx]) begin
                        r_kind <= before8[idx] ? KIND_HOLD : KIND_PRESS;
                    end else begin
                        r_kind <= KIND_RELEASE;
                    end
                end else begin
                    r_kind <= KIND_DONE;
                    r_row  <= '0;
                    r_last <= 1'b1;
                    r_clr  <= r_item.last_col && (r_count == 9'd0);
                    if (r_item.last_col) begin
                        r_count <= '0;
                    end
                end
            end
            if (i_load) begin
                r_item <= i_item;
            end
        end
    end

    assign o_valid             = r_valid;
    assign o_event_kind        = r_kind;
    assign o_key_row           = r_row;
    assign o_key_col           = r_col;
    assign o_clear_press_count = r_clr;
    assign o_last              = r_last;

endmodule

/* tb/key_matrix_edge_scanner_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_matrix_edge_scanner_tb
// Drives column samples through the scanner under random handshake gaps and
// checks every key event and column-done result against an in-bench predictor
// of the key map, scan column and net press count.
// ----------------------------------------------------------------------------
module key_matrix_edge_scanner_tb;
    import kmes_pkg::*;

    localparam logic [2:0] ADDR_COLS   = {CFG_IDX_COLS, 2'b00};
    localparam logic [2:0] ADDR_UNUSED = 3'd4;     // register index 1, not decoded
    localparam int         MAX_PRINTS  = 40;
    localparam int         ITEM_TARGET = 220;

    typedef struct packed {
        logic [1:0]       kind;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             clr;
        logic             lst;
    } t_key_event;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [MAX_ROWS-1:0] i_row_bits;
    logic                o_valid;
    logic                i_ready;
    logic [1:0]          o_event_kind;
    logic [ROW_W-1:0]    o_key_row;
    logic [COL_W-1:0]    o_key_col;
    logic                o_clear_press_count;
    logic                o_last;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    key_matrix_edge_scanner dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_row_bits          (i_row_bits),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_event_kind        (o_event_kind),
        .o_key_row           (o_key_row),
        .o_key_col           (o_key_col),
        .o_clear_press_count (o_clear_press_count),
        .o_last              (o_last),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    // 12 ns period
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // ------------------------------------------------------------------
    // Scanner state as the bench predicts it
    // ------------------------------------------------------------------
    logic [MAX_ROWS-1:0] key_map_model [MAP_DEPTH];
    logic [COL_W-1:0]    scan_col_model;
    logic [8:0]          net_presses;     // two's complement, wraps mod 512
    logic [CFG_W-1:0]    cols_setting;

    t_key_event pending_events [$];
    t_key_event head_event;
    int         error_count;
    int         items_sent;
    bit         steady_flow;              // both sides run without gaps

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    function automatic void queue_event(input logic [1:0] kind, input logic [ROW_W-1:0] row,
                                        input logic [COL_W-1:0] col, input logic clr,
                                        input logic lst);
        t_key_event ev;
        ev.kind = kind;
        ev.row  = row;
        ev.col  = col;
        ev.clr  = clr;
        ev.lst  = lst;
        pending_events.push_back(ev);
    endfunction

    // effective column count: 0 acts as 1, anything past the map saturates
    function automatic int unsigned active_columns();
        if (cols_setting == '0)
            return 1;
        if (cols_setting > MAP_DEPTH)
            return MAP_DEPTH;
        return cols_setting;
    endfunction

    // edge-detect one column sample against the stored map
    function automatic void predict_key_events(input logic [MAX_ROWS-1:0] bits);
        logic [COL_W-1:0]    col;
        logic [MAX_ROWS-1:0] was;
        col = scan_col_model;
        was = key_map_model[col];
        for (int r = 0; r < MAX_ROWS; r++) begin
            if (bits[r] && !was[r]) begin
                queue_event(KIND_PRESS, ROW_W'(r), col, 1'b0, 1'b0);
                net_presses = net_presses + 9'd1;
            end else if (bits[r] && was[r]) begin
                queue_event(KIND_HOLD, ROW_W'(r), col, 1'b0, 1'b0);
            end else if (!bits[r] && was[r]) begin
                queue_event(KIND_RELEASE, ROW_W'(r), col, 1'b0, 1'b0);
                net_presses = net_presses - 9'd1;
            end
        end
        key_map_model[col] = bits;
        // a column at or past the last counted one closes the scan
        if (int'(col) + 1 >= active_columns()) begin
            queue_event(KIND_DONE, '0, col, (net_presses == '0), 1'b1);
            scan_col_model = '0;
            net_presses    = '0;
        end else begin
            queue_event(KIND_DONE, '0, col, 1'b0, 1'b1);
            scan_col_model = col + 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Sample channel
    // ------------------------------------------------------------------
    task automatic send_row_sample(input logic [MAX_ROWS-1:0] bits);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 11);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_row_bits <= bits;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        predict_key_events(bits);
        items_sent++;
    endtask

    // drop valid, then hold off until every predicted result has come out
    task automatic wait_for_drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Config port (only used with the scanner idle)
    // ------------------------------------------------------------------
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_COLS)
            cols_setting = data[CFG_W-1:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_cols_readback();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_COLS;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {{(32-CFG_W){1'b0}}, cols_setting})
            report_mismatch($sformatf("cols_in_use read %0h, want %0h", prdata, cols_setting));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_columns(input logic [CFG_W-1:0] n);
        wait_for_drain();
        // upper data bits are junk on purpose; only the low five are kept
        apb_write(ADDR_COLS, {27'($urandom), n});
        check_cols_readback();
    endtask

    // ------------------------------------------------------------------
    // Result channel: random stall per result, checked at the rising edge
    // ------------------------------------------------------------------
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, 11);
            @(negedge i_clk);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_events.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d row %0d col %0d",
                                          o_event_kind, o_key_row, o_key_col));
            end else begin
                head_event = pending_events.pop_front();
                if (o_event_kind !== head_event.kind)
                    report_mismatch($sformatf("event_kind %0d, want %0d (col %0d row %0d)",
                        o_event_kind, head_event.kind, head_event.col, head_event.row));
                if (o_key_row !== head_event.row)
                    report_mismatch($sformatf("key_row %0d, want %0d (col %0d)",
                        o_key_row, head_event.row, head_event.col));
                if (o_key_col !== head_event.col)
                    report_mismatch($sformatf("key_col %0d, want %0d",
                        o_key_col, head_event.col));
                if (o_clear_press_count !== head_event.clr)
                    report_mismatch($sformatf("clear_press_count %0b, want %0b (col %0d)",
                        o_clear_press_count, head_event.clr, head_event.col));
                if (o_last !== head_event.lst)
                    report_mismatch($sformatf("last %0b, want %0b (col %0d row %0d)",
                        o_last, head_event.lst, head_event.col, head_event.row));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // single column: press, hold and release on every row, count returning to zero
    task automatic test_press_hold_release();
        set_columns(5'd1);
        send_row_sample(8'h00);     // nothing down: clear flagged
        send_row_sample(8'hFF);     // eight presses
        send_row_sample(8'hFF);     // eight holds, count back to zero
        send_row_sample(8'h00);     // eight releases
        send_row_sample(8'hA5);
        send_row_sample(8'h5A);     // four presses, four releases
        wait_for_drain();
    endtask

    // zero acts as one column, values past the map saturate to sixteen
    task automatic test_column_setting_extremes();
        set_columns(5'd0);
        send_row_sample(8'h81);
        send_row_sample(8'h7E);
        set_columns(5'd31);
        send_row_sample(8'h01);
        send_row_sample(8'h80);
        send_row_sample(8'hC3);
        wait_for_drain();
    endtask

    // scan column sits past a lowered count: it closes the scan and wraps
    task automatic test_column_beyond_count();
        set_columns(5'd2);
        send_row_sample(8'h3C);
        send_row_sample(8'h00);
        send_row_sample(8'hFF);
        wait_for_drain();
    endtask

    // write to an undecoded register must leave cols_in_use alone
    task automatic test_unused_register();
        wait_for_drain();
        apb_write(ADDR_UNUSED, 32'h0000_0001);
        check_cols_readback();
        send_row_sample(8'h55);
        send_row_sample(8'hAA);
        wait_for_drain();
    endtask

    // next sample mostly derived from the column's current map so keys are
    // held and released the way a real matrix behaves
    function automatic logic [MAX_ROWS-1:0] next_row_sample();
        logic [MAX_ROWS-1:0] m;
        m = key_map_model[scan_col_model];
        case ($urandom_range(0, 9))
            0: m = 8'h00;
            1: m = 8'hFF;
            2, 3: m = MAX_ROWS'($urandom);
            default: begin
                repeat ($urandom_range(0, 2))
                    m[$urandom_range(0, MAX_ROWS-1)] ^= 1'b1;
            end
        endcase
        return m;
    endfunction

    task automatic test_random_scans();
        logic [CFG_W-1:0] plan [7];
        int               phase;
        int               burst;
        int               stop_at;
        plan    = '{5'd4, 5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd3};
        phase   = 0;
        stop_at = items_sent + ITEM_TARGET;
        while (items_sent < stop_at) begin
            if (phase < 7)
                set_columns(plan[phase]);
            else
                set_columns(CFG_W'($urandom_range(0, 31)));
            steady_flow = ($urandom_range(0, 3) == 0);
            burst       = $urandom_range(8, 35);
            for (int k = 0; k < burst && items_sent < stop_at; k++) begin
                send_row_sample(next_row_sample());
                // occasional full stop mid-scan
                if ($urandom_range(0, 29) == 0)
                    wait_for_drain();
            end
            phase++;
        end
        steady_flow = 1'b0;
        wait_for_drain();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_row_bits = '0;
        i_ready    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        error_count = 0;
        items_sent  = 0;
        steady_flow = 1'b0;
        foreach (key_map_model[i])
            key_map_model[i] = '0;
        scan_col_model = '0;
        net_presses    = '0;
        cols_setting   = CFG_COLS_RST;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        check_cols_readback();
        test_press_hold_release();
        test_column_setting_extremes();
        test_column_beyond_count();
        test_unused_register();
        test_random_scans();

        wait_for_drain();
        repeat (20) @(posedge i_clk);
        if (error_count == 0)
            $display("key_matrix_edge_scanner_tb: done, clean");
        else
            $display("key_matrix_edge_scanner_tb: done, errors");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #3_000_000;
        $display("key_matrix_edge_scanner_tb: done, errors");
        $finish;
    end

endmodule
